[rtl/core/mwc_pkg.sv]
// Shared constants for the minimum covering window finder.
`timescale 1ns / 1ps

package mwc_pkg;

    localparam int CHAR_W       = 8;
    localparam int START_W      = 12;
    localparam int LENGTH_W     = 13;
    localparam int STATUS_W     = 2;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 32;

    localparam int TEXT_DEPTH_DEF = 4096;
    localparam int ALPHABET_DEF   = 256;

    // a pattern count stops rising here
    localparam int NEED_MAX = 8191;
    localparam int NEED_MIN_W = 14;

    localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

endpackage

[rtl/core/mwc_need_mem.sv]
// Need table: per byte value a seen flag and a signed need count, with valid bits.
`timescale 1ns / 1ps

module mwc_need_mem #(
    parameter int ALPHABET = mwc_pkg::ALPHABET_DEF,
    parameter int AW       = 8,
    parameter int DW       = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          clear
);

    logic [DW-1:0]       mem [ALPHABET];
    logic [DW-1:0]       q_reg;
    logic [ALPHABET-1:0] valid_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // an entry never written since the last job reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? q_reg : '0;

endmodule

[rtl/core/mwc_text_mem.sv]
// Text store: one write port at the right end, one read port at the left end.
`timescale 1ns / 1ps

module mwc_text_mem #(
    parameter int DEPTH = mwc_pkg::TEXT_DEPTH_DEF,
    parameter int AW    = 12
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [mwc_pkg::CHAR_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [mwc_pkg::CHAR_W-1:0] rd_data
);

    logic [mwc_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [mwc_pkg::CHAR_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    assign rd_data = q_reg;

endmodule

[rtl/core/min_window_cover_finder.sv]
// An in-alphabet pattern or text byte updates its need count; a stored text byte then
// runs shrink checks, with a left-edge step per met check (text read, need read, need
// write-back); over a job the left edge steps at most once per stored byte. S_FIN
// loads the result word once the job's last byte is through; a full output
// register holds the sequencer until taken. Reset (async, active low) and each job's
// end clear the need table valid bits and all window state at once.
`timescale 1ns / 1ps

module min_window_cover_finder #(
    parameter int TEXT_DEPTH = mwc_pkg::TEXT_DEPTH_DEF,
    parameter int ALPHABET   = mwc_pkg::ALPHABET_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mwc_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] char_value
    input  logic                            s_tuser,   // [0] mode
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mwc_pkg::OUT_TDATA_W-1:0] m_tdata    // [1:0] status, [13:2] win_start,
                                                       // [26:14] win_length, rest zero
);

    localparam int IDX_W  = $clog2(TEXT_DEPTH);
    localparam int CNT_W  = $clog2(TEXT_DEPTH + 1);
    localparam int AW     = $clog2(ALPHABET);
    localparam int UW     = $clog2(ALPHABET + 1);
    localparam int NEED_W = (IDX_W + 2 > mwc_pkg::NEED_MIN_W) ? IDX_W + 2 : mwc_pkg::NEED_MIN_W;
    localparam int DW     = NEED_W + 1;

    localparam logic signed [NEED_W-1:0] NEED_SAT = NEED_W'(mwc_pkg::NEED_MAX);
    localparam logic signed [NEED_W-1:0] NEED_ONE = NEED_W'(1);
    localparam logic [CNT_W-1:0]         FULL     = CNT_W'(TEXT_DEPTH);
    localparam logic [mwc_pkg::CHAR_W:0] ALPH_LIM = (mwc_pkg::CHAR_W + 1)'(ALPHABET);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PAT    = 3'd1;
    localparam logic [2:0] S_TAKE   = 3'd2;
    localparam logic [2:0] S_SHRINK = 3'd3;
    localparam logic [2:0] S_TXT    = 3'd4;
    localparam logic [2:0] S_GIVE   = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0]       state_reg,   state_next;
    logic             last_reg,    last_next;
    logic [AW-1:0]    addr_reg,    addr_next;
    logic [UW-1:0]    unmet_reg,   unmet_next;
    logic [CNT_W-1:0] left_reg,    left_next;
    logic [CNT_W-1:0] right_reg,   right_next;
    logic [IDX_W-1:0] bstart_reg,  bstart_next;
    logic [CNT_W-1:0] blen_reg,    blen_next;
    logic             ovf_reg,     ovf_next;
    logic             any_reg,     any_next;
    logic             ovalid_reg,  ovalid_next;
    logic [mwc_pkg::OUT_TDATA_W-1:0] odata_reg, odata_next;

    logic                      need_rd_en;
    logic [AW-1:0]             need_rd_addr;
    logic [DW-1:0]             need_rd_data;
    logic                      need_wr_en;
    logic [DW-1:0]             need_wr_data;
    logic                      need_clear;
    logic                      text_wr_en;
    logic                      text_rd_en;
    logic [mwc_pkg::CHAR_W-1:0] text_rd_data;

    logic                      accept;
    logic                      ch_ok;
    logic                      txt_ok;
    logic                      seen;
    logic signed [NEED_W-1:0]  need_cur;
    logic signed [NEED_W-1:0]  need_up;
    logic signed [NEED_W-1:0]  need_dn;
    logic [CNT_W-1:0]          win_len;
    logic                      out_free;
    logic [31:0]               start_ext;
    logic [31:0]               len_ext;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign ch_ok    = {1'b0, s_tdata} < ALPH_LIM;
    assign txt_ok   = {1'b0, text_rd_data} < ALPH_LIM;
    assign seen     = need_rd_data[DW-1];
    assign need_cur = $signed(need_rd_data[NEED_W-1:0]);
    assign need_up  = (need_cur < NEED_SAT) ? need_cur + NEED_ONE : need_cur;
    assign need_dn  = need_cur - NEED_ONE;
    assign win_len  = right_reg - left_reg;
    assign out_free = !ovalid_reg || m_tready;
    assign start_ext = 32'(bstart_reg);
    assign len_ext   = 32'(blen_reg);

    assign text_wr_en = (state_reg == S_IDLE) && accept && s_tuser && (right_reg != FULL);

    always_comb
    begin
        state_next   = state_reg;
        last_next    = last_reg;
        addr_next    = addr_reg;
        unmet_next   = unmet_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        bstart_next  = bstart_reg;
        blen_next    = blen_reg;
        ovf_next     = ovf_reg;
        any_next     = any_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        odata_next   = odata_reg;
        need_rd_en   = 1'b0;
        need_rd_addr = s_tdata[AW-1:0];
        need_wr_en   = 1'b0;
        need_wr_data = {1'b1, need_up};
        need_clear   = 1'b0;
        text_rd_en   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = s_tlast;
                    addr_next = s_tdata[AW-1:0];
                    if (!s_tuser)
                    begin
                        if (ch_ok)
                        begin
                            any_next   = 1'b1;
                            need_rd_en = 1'b1;
                            state_next = S_PAT;
                        end
                    end
                    else if (right_reg == FULL)
                    begin
                        // dropped byte; the overflow flag is set, and a last byte ends the job
                        ovf_next = 1'b1;
                        if (s_tlast)
                        begin
                            state_next = S_FIN;
                        end
                    end
                    else
                    begin
                        right_next = right_reg + CNT_W'(1);
                        if (ch_ok)
                        begin
                            need_rd_en = 1'b1;
                            state_next = S_TAKE;
                        end
                        else
                        begin
                            state_next = S_SHRINK;
                        end
                    end
                end
            end

            S_PAT:
            begin
                need_wr_en   = 1'b1;
                need_wr_data = {1'b1, need_up};
                if (need_up == NEED_ONE && need_cur != NEED_ONE)
                begin
                    unmet_next = unmet_reg + UW'(1);
                end
                state_next = S_IDLE;
            end

            S_TAKE:
            begin
                if (seen)
                begin
                    need_wr_en   = 1'b1;
                    need_wr_data = {1'b1, need_dn};
                    if (need_dn == '0)
                    begin
                        unmet_next = unmet_reg - UW'(1);
                    end
                end
                state_next = S_SHRINK;
            end

            S_SHRINK:
            begin
                if (any_reg && unmet_reg == '0 && left_reg < right_reg)
                begin
                    if (blen_reg == '0 || win_len < blen_reg)
                    begin
                        bstart_next = left_reg[IDX_W-1:0];
                        blen_next   = win_len;
                    end
                    text_rd_en = 1'b1;
                    state_next = S_TXT;
                end
                else if (last_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_TXT:
            begin
                left_next    = left_reg + CNT_W'(1);
                need_rd_addr = text_rd_data[AW-1:0];
                addr_next    = text_rd_data[AW-1:0];
                if (txt_ok)
                begin
                    need_rd_en = 1'b1;
                    state_next = S_GIVE;
                end
                else
                begin
                    state_next = S_SHRINK;
                end
            end

            S_GIVE:
            begin
                if (seen)
                begin
                    need_wr_en   = 1'b1;
                    need_wr_data = {1'b1, need_up};
                    if (need_up == NEED_ONE && need_cur != NEED_ONE)
                    begin
                        unmet_next = unmet_reg + UW'(1);
                    end
                end
                state_next = S_SHRINK;
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = '0;
                    if (ovf_reg)
                    begin
                        odata_next[1:0] = mwc_pkg::STATUS_OVERFLOW;
                    end
                    else if (blen_reg != '0)
                    begin
                        odata_next[1:0]   = mwc_pkg::STATUS_FOUND;
                        odata_next[13:2]  = start_ext[mwc_pkg::START_W-1:0];
                        odata_next[26:14] = len_ext[mwc_pkg::LENGTH_W-1:0];
                    end
                    else
                    begin
                        odata_next[1:0] = mwc_pkg::STATUS_NONE;
                    end
                    // back to the reset state for the next job
                    need_clear  = 1'b1;
                    unmet_next  = '0;
                    left_next   = '0;
                    right_next  = '0;
                    bstart_next = '0;
                    blen_next   = '0;
                    ovf_next    = 1'b0;
                    any_next    = 1'b0;
                    last_next   = 1'b0;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            last_reg   <= 1'b0;
            unmet_reg  <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            bstart_reg <= '0;
            blen_reg   <= '0;
            ovf_reg    <= 1'b0;
            any_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            unmet_reg  <= unmet_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            bstart_reg <= bstart_next;
            blen_reg   <= blen_next;
            ovf_reg    <= ovf_next;
            any_reg    <= any_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        odata_reg <= odata_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    mwc_need_mem #(
        .ALPHABET (ALPHABET),
        .AW       (AW),
        .DW       (DW)
    ) u_need (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (need_rd_en),
        .rd_addr (need_rd_addr),
        .rd_data (need_rd_data),
        .wr_en   (need_wr_en),
        .wr_addr (addr_reg),
        .wr_data (need_wr_data),
        .clear   (need_clear)
    );

    mwc_text_mem #(
        .DEPTH (TEXT_DEPTH),
        .AW    (IDX_W)
    ) u_text (
        .clk     (clk),
        .wr_en   (text_wr_en),
        .wr_addr (right_reg[IDX_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (text_rd_en),
        .rd_addr (left_reg[IDX_W-1:0]),
        .rd_data (text_rd_data)
    );

endmodule

[sim/mwc_window_checker.sv]
// Watches both stream channels, predicts each job's window result and compares.
`timescale 1ns / 1ps

module mwc_window_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mwc_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] char_value
    input  logic                            s_tuser,   // [0] mode
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mwc_pkg::OUT_TDATA_W-1:0] m_tdata,   // [1:0] status, [13:2] win_start,
                                                       // [26:14] win_length
    output int                              mismatches,
    output int                              outstanding
);

    localparam int DEPTH  = mwc_pkg::TEXT_DEPTH_DEF;
    localparam int ALPH   = mwc_pkg::ALPHABET_DEF;
    localparam int SHOWN  = 10;
    localparam int QDEPTH = 8;
    localparam int QW     = 3;

    typedef struct packed {
        logic [mwc_pkg::STATUS_W-1:0] status;
        logic [mwc_pkg::START_W-1:0]  start;
        logic [mwc_pkg::LENGTH_W-1:0] length;
    } window_result_t;

    logic signed [mwc_pkg::NEED_MIN_W-1:0] need [ALPH];
    bit                                    required [ALPH];
    logic [mwc_pkg::CHAR_W-1:0]            text_mem [DEPTH];
    logic [8:0]                            unmet;
    logic [12:0]                           lo;
    logic [12:0]                           hi;
    logic [mwc_pkg::START_W-1:0]           best_at;
    logic [mwc_pkg::LENGTH_W-1:0]          best_len;
    bit                                    overflowed;
    bit                                    have_pattern;

    // expected results waiting for their output word
    window_result_t result_fifo [QDEPTH];
    logic [QW-1:0]  fifo_wr;
    logic [QW-1:0]  fifo_rd;
    int             fifo_count;
    window_result_t got;
    window_result_t want;
    int             fail_tally;

    function automatic void clear_job();
        for (int i = 0; i < ALPH; i++) begin
            need[i]     = '0;
            required[i] = 1'b0;
        end
        unmet        = '0;
        lo           = '0;
        hi           = '0;
        best_at      = '0;
        best_len     = '0;
        overflowed   = 1'b0;
        have_pattern = 1'b0;
    endfunction

    function automatic void release_char(logic [mwc_pkg::CHAR_W-1:0] c);
        if (required[c]) begin
            if (need[c] < mwc_pkg::NEED_MAX)
                need[c]++;
            if (need[c] == 1)
                unmet++;
        end
    endfunction

    function automatic void consume_char(logic [mwc_pkg::CHAR_W-1:0] c);
        if (required[c]) begin
            need[c]--;
            if (need[c] == 0)
                unmet--;
        end
    endfunction

    // one accepted input word; a last text word closes the job
    function automatic void absorb_word(logic is_text, logic [mwc_pkg::CHAR_W-1:0] c,
                                        logic is_last);
        window_result_t r;
        logic [12:0]    span;
        if (!is_text) begin
            required[c]  = 1'b1;
            have_pattern = 1'b1;
            release_char(c);
            return;
        end
        if (hi >= DEPTH) begin
            overflowed = 1'b1;
        end
        else begin
            text_mem[hi[11:0]] = c;
            hi++;
            consume_char(c);
            while (have_pattern && unmet == 0 && lo < hi) begin
                span = hi - lo;
                if (best_len == 0 || span < best_len) begin
                    best_at  = lo[11:0];
                    best_len = span;
                end
                release_char(text_mem[lo[11:0]]);
                lo++;
            end
        end
        if (!is_last)
            return;
        if (overflowed)
            r = '{mwc_pkg::STATUS_OVERFLOW, '0, '0};
        else if (best_len != 0)
            r = '{mwc_pkg::STATUS_FOUND, best_at, best_len};
        else
            r = '{mwc_pkg::STATUS_NONE, '0, '0};
        result_fifo[fifo_wr] = r;
        fifo_wr++;
        fifo_count++;
        clear_job();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clear_job();
            fifo_wr     = '0;
            fifo_rd     = '0;
            fifo_count  = 0;
            fail_tally  = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[1:0], m_tdata[13:2], m_tdata[26:14]};
                if (fifo_count == 0) begin
                    fail_tally++;
                    if (fail_tally <= SHOWN)
                        $display("%0t: unexpected result word: status %0d start %0d length %0d",
                                 $realtime, got.status, got.start, got.length);
                end
                else begin
                    want = result_fifo[fifo_rd];
                    fifo_rd++;
                    fifo_count--;
                    if (got.status !== want.status || got.start !== want.start ||
                        got.length !== want.length) begin
                        fail_tally++;
                        if (fail_tally <= SHOWN)
                            $display("%0t: window mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, want.status, want.start, want.length,
                                     got.status, got.start, got.length);
                    end
                end
            end
            if (s_tvalid && s_tready)
                absorb_word(s_tuser, s_tdata[mwc_pkg::CHAR_W-1:0], s_tlast);
            mismatches  <= fail_tally;
            outstanding <= fifo_count;
        end
    end

endmodule

[sim/testbench.sv]
// Stimulus, stalls, watchdog and verdict for the minimum covering window finder.
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT  = 50000;
    localparam int PHASE_WORDS  = 265;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 200;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [mwc_pkg::IN_TDATA_W-1:0]  s_tdata;   // [7:0] char_value
    logic                            s_tuser;   // [0] mode
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [mwc_pkg::OUT_TDATA_W-1:0] m_tdata;   // [1:0] status, [13:2] win_start,
                                                // [26:14] win_length

    int mismatches;
    int outstanding;
    int send_idle;
    int recv_stall;
    bit hold_req;
    int words_sent;

    localparam logic PATTERN = 1'b0;
    localparam logic TEXT    = 1'b1;

    min_window_cover_finder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mwc_window_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus one long hold-off when requested
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else begin
                m_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else if (++quiet >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(input logic is_text, input logic [7:0] c, input logic is_last);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= is_text;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    // small alphabet so windows are found often; a few stray bytes and late pattern bytes
    task automatic random_job();
        int         k;
        int         plen;
        int         tlen;
        logic [7:0] pool [8];
        logic [7:0] c;
        k = $urandom_range(2, 8);
        for (int i = 0; i < 8; i++)
            pool[i] = 8'($urandom_range(255));
        plen = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
        for (int i = 0; i < plen; i++)
            send_word(PATTERN, pool[$urandom_range(k - 1)], 1'($urandom_range(1)));
        tlen = $urandom_range(1, 30);
        for (int t = 0; t < tlen; t++) begin
            if ($urandom_range(19) == 0)
                send_word(PATTERN, pool[$urandom_range(k - 1)], 1'($urandom_range(1)));
            c = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : pool[$urandom_range(k - 1)];
            send_word(TEXT, c, t == tlen - 1);
        end
    endtask

    initial
    begin
        int phase_start;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= 1'b0;
        s_tlast    <= 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        hold_req   = 0;
        words_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // last on a pattern word is ignored
        send_word(PATTERN, 8'h00, 1'b1);
        send_word(PATTERN, 8'hFF, 1'b0);
        send_word(TEXT, 8'hFF, 1'b0);
        send_word(TEXT, 8'h12, 1'b0);
        send_word(TEXT, 8'h00, 1'b0);
        send_word(TEXT, 8'hFF, 1'b0);
        send_word(TEXT, 8'h00, 1'b1);
        // empty pattern
        send_word(TEXT, 8'h55, 1'b0);
        send_word(TEXT, 8'hAA, 1'b1);
        // pattern never met
        send_word(PATTERN, 8'h55, 1'b0);
        send_word(TEXT, 8'hAA, 1'b1);
        // one-byte window
        send_word(PATTERN, 8'h7F, 1'b0);
        send_word(TEXT, 8'h7F, 1'b1);
        // tie between equal windows
        send_word(PATTERN, 8'h01, 1'b0);
        send_word(PATTERN, 8'h02, 1'b0);
        send_word(TEXT, 8'h01, 1'b0);
        send_word(TEXT, 8'h02, 1'b0);
        send_word(TEXT, 8'h01, 1'b1);
        // pattern arriving after text, repeated pattern byte
        send_word(TEXT, 8'h10, 1'b0);
        send_word(TEXT, 8'h20, 1'b0);
        send_word(PATTERN, 8'h20, 1'b0);
        send_word(PATTERN, 8'h20, 1'b1);
        send_word(TEXT, 8'h20, 1'b0);
        send_word(TEXT, 8'h10, 1'b0);
        send_word(TEXT, 8'h20, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  hold_req = 1; end
                1: begin send_idle = 84; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 84; end
                default: begin send_idle = 22; recv_stall = 22; end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
                random_job();
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mwc_pkg.sv
rtl/core/mwc_need_mem.sv
rtl/core/mwc_text_mem.sv
rtl/core/min_window_cover_finder.sv
sim/mwc_window_checker.sv
sim/testbench.sv
